// ===== hw/rtl/gcur_pkg.sv =====
`default_nettype none
package gcur_pkg;

	// grid geometry
	localparam int CELL_LOG2  = 7;
	localparam int GRID_CELLS = 4096;
	localparam int ADDR_W     = $clog2(GRID_CELLS);

	// pixel and cell coordinate widths
	localparam int LT_W  = 13;
	localparam int PIX_W = 14;
	localparam int CC_W  = PIX_W - CELL_LOG2;

	// stride register
	localparam int          GWL_W     = 3;
	localparam int          SHIFT_MAX = (1 << GWL_W) - 1;
	localparam logic [2:0]  GWL_RESET = 3'd6;

	// linear cell index, wide enough for shifted row plus column plus one stride
	localparam int IDX_W = CC_W + SHIFT_MAX + 1;

	// opcodes
	localparam int         OP_W     = 2;
	localparam logic [1:0] OP_MARK  = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	// trimming passes
	localparam logic [1:0] PASS_TOP   = 2'd0;
	localparam logic [1:0] PASS_BOT   = 2'd1;
	localparam logic [1:0] PASS_LEFT  = 2'd2;
	localparam logic [1:0] PASS_RIGHT = 2'd3;

	// input beat layout
	localparam int IN_IDX_LO   = 0;
	localparam int IN_LEFT_LO  = IN_IDX_LO + ADDR_W;
	localparam int IN_TOP_LO   = IN_LEFT_LO + LT_W;
	localparam int IN_RIGHT_LO = IN_TOP_LO + LT_W;
	localparam int IN_BOT_LO   = IN_RIGHT_LO + PIX_W;
	localparam int IN_USED_W   = IN_BOT_LO + PIX_W;
	localparam int IN_DATA_W   = ((IN_USED_W + 7) / 8) * 8;

	// output beat layout
	localparam int OUT_DATA_W = ((4 * PIX_W + 7) / 8) * 8;

	// linear index of a cell from row, column and stride shift
	function automatic logic [IDX_W-1:0] cell_idx(input logic [CC_W-1:0] row,
		input logic [CC_W-1:0] col, input logic [GWL_W-1:0] k);
		return (IDX_W'(row) << k) + IDX_W'(col);
	endfunction

	// pixel edge of a cell coordinate
	function automatic logic [PIX_W-1:0] cell_pix(input logic [CC_W-1:0] c);
		return PIX_W'(c) << CELL_LOG2;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/gcur_ram.sv =====
`default_nettype none
module gcur_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== hw/rtl/grid_cache_uncovered_rect_shrink_core.sv =====
`default_nettype none
// Grid cache map with uncached-rectangle query.
// Input stream s_*: tuser carries the opcode (mark, clear, query), tdata the cell
// index and the pixel rectangle. Only a query gives an output beat on m_*, with
// the remaining rectangle in tdata and the all-cached flag in tuser.
// cfg_* writes the row stride shift; it is always ready. The user must write it
// only while idle; the block itself does not enforce this. A mark writes its bit
// as the beat is taken. Clear sweeps the bit map, one cell per cycle.
// A query takes a setup step, then per pass a step to form the start index, a
// map read (registered RAM port) and an evaluation step per cell visited, one
// more step per trimmed row or column, and a step to load the output register.
// An empty rectangle goes from setup straight to the load; the walk is longest
// on an aliased, fully cached area. s_tready returns high as the result loads.
// The single map read port and the shared index adder limit the walk to one cell
// at a time. After reset the same clearing sweep runs with s_tready low.
// s_tready is high only while idle; a finished result waits in the output
// register while the next beat is accepted, and a further query holds at its end
// until that register has been taken.
module grid_cache_uncovered_rect_shrink_core
	import gcur_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// cell_index, rect_left, rect_top, rect_right, rect_bottom, zero fill
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	// opcode
	input  wire logic [OP_W-1:0]       s_tuser,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// rem_left, rem_top, rem_right, rem_bottom
	output logic      [OUT_DATA_W-1:0] m_tdata,
	// all_cached
	output logic                       m_tuser,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [GWL_W-1:0]      cfg_data
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_SETUP = 3'd2;
	localparam logic [2:0] ST_INIT  = 3'd3;
	localparam logic [2:0] ST_READ  = 3'd4;
	localparam logic [2:0] ST_EVAL  = 3'd5;
	localparam logic [2:0] ST_EMIT  = 3'd6;

	localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(GRID_CELLS - 1);

	logic [2:0]            state_q;
	logic [1:0]            pass_q;
	logic [ADDR_W-1:0]     clr_q;
	logic [GWL_W-1:0]      gwl_q;
	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic                  m_tuser_q;

	logic [LT_W-1:0]       in_l_q, in_t_q;
	logic [PIX_W-1:0]      in_r_q, in_b_q;
	logic [CC_W-1:0]       row_t_q, row_b_q, col_l_q, col_r_q;
	logic [IDX_W-1:0]      pos_q, end_q;
	logic                  raw_q, flag_q;

	logic                  in_fire, out_free, is_empty, cached, past_end;
	logic                  top_done, left_done;
	logic [PIX_W-1:0]      b_m1, r_m1;
	logic [IDX_W-1:0]      stride, step, nxt_idx, init_beg, init_end;
	logic [CC_W-1:0]       row_t_inc, col_l_inc;
	logic [OUT_DATA_W-1:0] res_data;
	logic [ADDR_W-1:0]     mark_idx;

	logic                  ram_we;
	logic [ADDR_W-1:0]     ram_waddr;
	logic [0:0]            ram_wdata, ram_rdata;

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign m_tuser   = m_tuser_q;

	assign in_fire  = s_tvalid & s_tready;
	assign out_free = ~m_tvalid_q | m_tready;
	assign mark_idx = s_tdata[IN_IDX_LO +: ADDR_W];

	// bit map: clearing sweep or a mark beat
	always_comb begin
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = 1'b0;
		end else begin
			ram_we    = in_fire && (s_tuser == OP_MARK)
				&& ((ADDR_W + 1)'(mark_idx) < (ADDR_W + 1)'(GRID_CELLS));
			ram_waddr = mark_idx;
			ram_wdata = 1'b1;
		end
	end

	gcur_ram #(
		.WIDTH(1),
		.DEPTH(GRID_CELLS)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(pos_q[ADDR_W-1:0]),
		.rdata(ram_rdata)
	);

	// query setup, index walk and result forming
	always_comb begin
		is_empty  = (in_r_q <= PIX_W'(in_l_q)) || (in_b_q <= PIX_W'(in_t_q));
		b_m1      = in_b_q - PIX_W'(1);
		r_m1      = in_r_q - PIX_W'(1);
		stride    = IDX_W'(1) << gwl_q;
		cached    = ram_rdata[0] && (pos_q < IDX_W'(GRID_CELLS));
		step      = (pass_q == PASS_TOP || pass_q == PASS_BOT) ? IDX_W'(1) : stride;
		nxt_idx   = pos_q + step;
		past_end  = nxt_idx > end_q;
		row_t_inc = row_t_q + CC_W'(1);
		col_l_inc = col_l_q + CC_W'(1);
		top_done  = row_t_inc == (row_b_q + CC_W'(1));
		left_done = col_l_inc == (col_r_q + CC_W'(1));
		case (pass_q)
			PASS_TOP: begin
				init_beg = cell_idx(row_t_q, col_l_q, gwl_q);
				init_end = cell_idx(row_t_q, col_r_q, gwl_q);
			end
			PASS_BOT: begin
				init_beg = cell_idx(row_b_q, col_l_q, gwl_q);
				init_end = cell_idx(row_b_q, col_r_q, gwl_q);
			end
			PASS_LEFT: begin
				init_beg = cell_idx(row_t_q, col_l_q, gwl_q);
				init_end = cell_idx(row_b_q, col_l_q, gwl_q);
			end
			default: begin
				init_beg = cell_idx(row_t_q, col_r_q, gwl_q);
				init_end = cell_idx(row_b_q, col_r_q, gwl_q);
			end
		endcase
		res_data = '0;
		if (raw_q) begin
			res_data[0 +: PIX_W]         = PIX_W'(in_l_q);
			res_data[PIX_W +: PIX_W]     = PIX_W'(in_t_q);
			res_data[2 * PIX_W +: PIX_W] = in_r_q;
			res_data[3 * PIX_W +: PIX_W] = in_b_q;
		end else begin
			res_data[0 +: PIX_W]         = cell_pix(col_l_q);
			res_data[PIX_W +: PIX_W]     = cell_pix(row_t_q);
			res_data[2 * PIX_W +: PIX_W] = cell_pix(col_r_q + CC_W'(1));
			res_data[3 * PIX_W +: PIX_W] = cell_pix(row_b_q + CC_W'(1));
		end
	end

	// sequencer and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			pass_q     <= PASS_TOP;
			clr_q      <= '0;
			gwl_q      <= GWL_RESET;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				gwl_q <= cfg_data;
			end
			// a beat taken while the next result loads keeps valid high
			if (m_tvalid_q && m_tready && (state_q != ST_EMIT)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == CLR_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_fire) begin
						case (s_tuser)
							OP_CLEAR: begin
								clr_q   <= '0;
								state_q <= ST_CLEAR;
							end
							OP_QUERY: state_q <= ST_SETUP;
							default: ;
						endcase
					end
				end
				ST_SETUP: begin
					pass_q  <= PASS_TOP;
					state_q <= is_empty ? ST_EMIT : ST_INIT;
				end
				ST_INIT: state_q <= ST_READ;
				ST_READ: state_q <= ST_EVAL;
				ST_EVAL: begin
					if (!cached) begin
						case (pass_q)
							PASS_TOP: begin
								pass_q  <= PASS_BOT;
								state_q <= ST_INIT;
							end
							PASS_BOT: begin
								pass_q  <= PASS_LEFT;
								state_q <= ST_INIT;
							end
							PASS_LEFT: begin
								pass_q  <= PASS_RIGHT;
								state_q <= ST_INIT;
							end
							default: state_q <= ST_EMIT;
						endcase
					end else if (past_end) begin
						case (pass_q)
							PASS_TOP:  state_q <= top_done ? ST_EMIT : ST_INIT;
							PASS_LEFT: state_q <= left_done ? ST_EMIT : ST_INIT;
							default:   state_q <= ST_INIT;
						endcase
					end else begin
						state_q <= ST_READ;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// rectangle, walk position and output payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					in_l_q <= s_tdata[IN_LEFT_LO +: LT_W];
					in_t_q <= s_tdata[IN_TOP_LO +: LT_W];
					in_r_q <= s_tdata[IN_RIGHT_LO +: PIX_W];
					in_b_q <= s_tdata[IN_BOT_LO +: PIX_W];
				end
			end
			ST_SETUP: begin
				raw_q   <= is_empty;
				flag_q  <= 1'b1;
				row_t_q <= CC_W'(in_t_q >> CELL_LOG2);
				col_l_q <= CC_W'(in_l_q >> CELL_LOG2);
				row_b_q <= CC_W'(b_m1 >> CELL_LOG2);
				col_r_q <= CC_W'(r_m1 >> CELL_LOG2);
			end
			ST_INIT: begin
				pos_q <= init_beg;
				end_q <= init_end;
			end
			ST_EVAL: begin
				if (!cached) begin
					if (pass_q == PASS_RIGHT) begin
						flag_q <= 1'b0;
					end
				end else if (past_end) begin
					case (pass_q)
						PASS_TOP:  row_t_q <= row_t_inc;
						PASS_BOT:  row_b_q <= row_b_q - CC_W'(1);
						PASS_LEFT: col_l_q <= col_l_inc;
						default:   col_r_q <= col_r_q - CC_W'(1);
					endcase
				end else begin
					pos_q <= nxt_idx;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					m_tdata_q <= res_data;
					m_tuser_q <= flag_q;
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// ===== tb/grid_cache_uncovered_rect_shrink_core_tb.sv =====
`timescale 1ns / 100ps
module grid_cache_uncovered_rect_shrink_core_tb;
	import gcur_pkg::*;

	localparam int         CELL_PIX      = 1 << CELL_LOG2;
	localparam logic [1:0] OP_SPARE      = 2'd3;
	localparam int         PHASES        = 10;
	localparam int         ITEM_TARGET   = 1150;
	localparam int         SETTLE_CYCLES = 4200;
	localparam int         HOLD_CYCLES   = 300;
	localparam int         QUIET_LIMIT   = 200000;

	typedef struct packed {
		logic [PIX_W-1:0] left;
		logic [PIX_W-1:0] top;
		logic [PIX_W-1:0] right;
		logic [PIX_W-1:0] bottom;
		logic             all_cached;
	} rect_res_t;

	// cache map mirror, stride shift and the queue of rectangles still owed
	class grid_cache_tracker;
		bit               cached [GRID_CELLS];
		logic [GWL_W-1:0] shift;
		rect_res_t        expected_rects [$];
		int               errors;

		function new();
			foreach (cached[i]) cached[i] = 1'b0;
			shift  = GWL_RESET;
			errors = 0;
		endfunction

		function void set_shift(logic [GWL_W-1:0] k);
			shift = k;
		endfunction

		function int pending();
			return expected_rects.size();
		endfunction

		// cells past the end of the map read as uncached
		function bit is_cached(longint idx);
			if (idx < 0 || idx >= GRID_CELLS)
				return 1'b0;
			return cached[idx];
		endfunction

		// row shifted by the stride plus column, no masking of the column
		function longint cell_at(longint x, longint y);
			return ((y / CELL_PIX) << shift) + x / CELL_PIX;
		endfunction

		function rect_res_t make_rect(longint l, longint t, longint r, longint b, bit flag);
			rect_res_t res;
			res.left       = PIX_W'(l);
			res.top        = PIX_W'(t);
			res.right      = PIX_W'(r);
			res.bottom     = PIX_W'(b);
			res.all_cached = flag;
			return res;
		endfunction

		// widen to cell edges, then peel cached top rows, bottom rows, left and right columns
		function rect_res_t trim_query(longint l, longint t, longint r, longint b);
			longint stride, tl, tr, bl, br, beg, fin, pos;
			stride = longint'(1) << shift;
			if (r <= l || b <= t)
				return make_rect(l, t, r, b, 1'b1);
			l = (l / CELL_PIX) * CELL_PIX;
			t = (t / CELL_PIX) * CELL_PIX;
			r = ((r - 1) / CELL_PIX + 1) * CELL_PIX;
			b = ((b - 1) / CELL_PIX + 1) * CELL_PIX;
			tl = cell_at(l, t);
			tr = cell_at(r - 1, t);
			bl = cell_at(l, b - 1);
			br = cell_at(r - 1, b - 1);

			// top rows
			beg = tl;
			fin = tr;
			pos = beg;
			while (is_cached(pos)) begin
				pos++;
				if (pos > fin) begin
					t += CELL_PIX;
					if (t == b)
						return make_rect(l, t, r, b, 1'b1);
					beg += stride;
					fin += stride;
					pos = beg;
				end
			end
			tl = beg;
			tr = fin;

			// bottom rows
			beg = bl;
			fin = br;
			pos = beg;
			while (is_cached(pos)) begin
				pos++;
				if (pos > fin) begin
					b -= CELL_PIX;
					beg -= stride;
					fin -= stride;
					pos = beg;
				end
			end
			bl = beg;
			br = fin;

			// left columns
			beg = tl;
			fin = bl;
			pos = beg;
			while (is_cached(pos)) begin
				pos += stride;
				if (pos > fin) begin
					l += CELL_PIX;
					if (l == r)
						return make_rect(l, t, r, b, 1'b1);
					beg += 1;
					fin += 1;
					pos = beg;
				end
			end

			// right columns
			beg = tr;
			fin = br;
			pos = beg;
			while (is_cached(pos)) begin
				pos += stride;
				if (pos > fin) begin
					r -= CELL_PIX;
					beg -= 1;
					fin -= 1;
					pos = beg;
				end
			end
			return make_rect(l, t, r, b, 1'b0);
		endfunction

		function void apply_request(logic [OP_W-1:0] op, logic [IN_DATA_W-1:0] d);
			logic [ADDR_W-1:0] idx;
			idx = d[IN_IDX_LO +: ADDR_W];
			case (op)
				OP_MARK: begin
					if (idx < GRID_CELLS)
						cached[idx] = 1'b1;
				end
				OP_CLEAR: begin
					foreach (cached[i]) cached[i] = 1'b0;
				end
				OP_QUERY: begin
					expected_rects.push_back(trim_query(d[IN_LEFT_LO +: LT_W],
						d[IN_TOP_LO +: LT_W], d[IN_RIGHT_LO +: PIX_W],
						d[IN_BOT_LO +: PIX_W]));
				end
				default: ;
			endcase
		endfunction

		function void check_rect(logic [OUT_DATA_W-1:0] d, logic flag);
			rect_res_t want, got;
			got.left       = d[0 +: PIX_W];
			got.top        = d[PIX_W +: PIX_W];
			got.right      = d[2*PIX_W +: PIX_W];
			got.bottom     = d[3*PIX_W +: PIX_W];
			got.all_cached = flag;
			if (expected_rects.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("result with none expected: l=%0d t=%0d r=%0d b=%0d all=%0b",
						got.left, got.top, got.right, got.bottom, got.all_cached);
				return;
			end
			want = expected_rects.pop_front();
			if (got.left !== want.left || got.top !== want.top || got.right !== want.right
				|| got.bottom !== want.bottom || got.all_cached !== want.all_cached) begin
				errors++;
				if (errors <= 10)
					$display({"rect mismatch: exp l=%0d t=%0d r=%0d b=%0d all=%0b,",
						" got l=%0d t=%0d r=%0d b=%0d all=%0b"},
						want.left, want.top, want.right, want.bottom, want.all_cached,
						got.left, got.top, got.right, got.bottom, got.all_cached);
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic [OP_W-1:0]       s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [GWL_W-1:0]      cfg_data;

	grid_cache_tracker tracker = new();
	int                tx_idle_pct  = 0;
	int                rx_stall_pct = 0;
	int                items_sent   = 0;
	int                quiet_cycles = 0;
	logic              squeeze_req  = 1'b0;
	logic [GWL_W-1:0]  cur_shift    = GWL_RESET;

	// per-phase stride shift and idling plans
	logic [GWL_W-1:0]  shift_plan [PHASES] = '{3'd6, 3'd0, 3'd7, 3'd3, 3'd6,
		3'd1, 3'd5, 3'd2, 3'd4, 3'd7};
	int                tx_plan [4]         = '{0, 53, 0, 24};
	int                rx_plan [4]         = '{0, 0, 53, 24};

	grid_cache_uncovered_rect_shrink_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// beat monitor: results are checked before the same edge's input is noted
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				tracker.check_rect(m_tdata, m_tuser);
			if (s_tvalid && s_tready)
				tracker.apply_request(s_tuser, s_tdata);
			if (cfg_valid && cfg_ready)
				tracker.set_shift(cfg_data);
		end
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
			|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// output side: random stalls, plus one long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (squeeze_req) begin
				squeeze_req <= 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_tready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	function automatic logic [IN_DATA_W-1:0] pack_request(int idx, int l, int t, int r, int b);
		logic [IN_DATA_W-1:0] d;
		d = '0;
		d[IN_IDX_LO +: ADDR_W]  = idx[ADDR_W-1:0];
		d[IN_LEFT_LO +: LT_W]   = l[LT_W-1:0];
		d[IN_TOP_LO +: LT_W]    = t[LT_W-1:0];
		d[IN_RIGHT_LO +: PIX_W] = r[PIX_W-1:0];
		d[IN_BOT_LO +: PIX_W]   = b[PIX_W-1:0];
		return d;
	endfunction

	// offer one beat, possibly after an idle gap, and wait until it is taken
	task automatic send_beat(input logic [OP_W-1:0] op, input logic [IN_DATA_W-1:0] data);
		int gap;
		gap = 0;
		if ($urandom_range(99) < tx_idle_pct)
			gap = ($urandom_range(7) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 4);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= data;
		do @(posedge clk); while (!s_tready);
		if (op != OP_SPARE)
			items_sent++;
	endtask

	task automatic mark_cell(input int idx);
		send_beat(OP_MARK, pack_request(idx, $urandom, $urandom, $urandom, $urandom));
	endtask

	task automatic query_rect(input int l, input int t, input int r, input int b);
		send_beat(OP_QUERY, pack_request($urandom, l, t, r, b));
	endtask

	// let every owed result come back and any clear sweep finish
	task automatic drain_block();
		s_tvalid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_grid_shift(input logic [GWL_W-1:0] k);
		cfg_valid <= 1'b1;
		cfg_data  <= k;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_shift = k;
	endtask

	// cache a block of cells with cached edge bands and holes, then query around it
	task automatic run_region();
		int  w, h, c0, r0, nt, nb, nl, nr, colmax, nq, lo_c, hi_c, lo_r, hi_r;
		bit  full, hit;
		longint idx;
		w = ($urandom_range(7) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 4);
		h = ($urandom_range(7) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 4);
		colmax = (cur_shift < 6) ? (1 << cur_shift) : 64;
		if (colmax >= w && $urandom_range(3) != 0)
			c0 = $urandom_range(0, colmax - w);
		else
			c0 = $urandom_range(0, 64 - w);
		r0 = $urandom_range(0, 64 - h);
		full = ($urandom_range(5) == 0);
		nt = $urandom_range(0, h);
		nb = $urandom_range(0, h);
		nl = $urandom_range(0, w);
		nr = $urandom_range(0, w);
		if ($urandom_range(13) == 0)
			send_beat(OP_CLEAR, pack_request($urandom, $urandom, $urandom, $urandom, $urandom));
		for (int row = 0; row < h; row++) begin
			for (int col = 0; col < w; col++) begin
				hit = full || row < nt || row >= h - nb || col < nl || col >= w - nr
					|| $urandom_range(9) == 0;
				idx = (longint'(r0 + row) << cur_shift) + c0 + col;
				if (hit && idx < GRID_CELLS)
					mark_cell(int'(idx));
			end
		end
		nq = $urandom_range(1, 3);
		repeat (nq) begin
			lo_c = c0;
			hi_c = c0 + w - 1;
			lo_r = r0;
			hi_r = r0 + h - 1;
			// sometimes widen one edge by a cell
			case ($urandom_range(7))
				0: if (lo_c > 0) lo_c--;
				1: if (hi_c < 63) hi_c++;
				2: if (lo_r > 0) lo_r--;
				3: if (hi_r < 63) hi_r++;
				default: ;
			endcase
			query_rect(lo_c * CELL_PIX + $urandom_range(0, CELL_PIX - 1),
				lo_r * CELL_PIX + $urandom_range(0, CELL_PIX - 1),
				hi_c * CELL_PIX + $urandom_range(1, CELL_PIX),
				hi_r * CELL_PIX + $urandom_range(1, CELL_PIX));
		end
	endtask

	// stray marks, full-range and local random queries and the unused opcode
	task automatic send_noise();
		int l, t, sel;
		sel = $urandom_range(99);
		l = $urandom_range(0, 8191);
		t = $urandom_range(0, 8191);
		if (sel < 35)
			mark_cell($urandom_range(0, GRID_CELLS - 1));
		else if (sel < 55)
			query_rect(l, t, $urandom_range(0, 16383), $urandom_range(0, 16383));
		else if (sel < 85)
			query_rect(l, t, l + $urandom_range(0, 700), t + $urandom_range(0, 700));
		else
			send_beat(OP_SPARE, pack_request($urandom, $urandom, $urandom, $urandom,
				$urandom));
	endtask

	initial begin
		int target;

		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = OP_MARK;
		cfg_valid = 1'b0;
		cfg_data  = GWL_RESET;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at the reset stride of 64 cells
		query_rect(100, 5, 100, 50);
		query_rect(0, 8191, 8192, 0);
		query_rect(0, 0, 1, 1);
		query_rect(8191, 8191, 8192, 8192);
		mark_cell(0);
		mark_cell(1);
		mark_cell(64);
		mark_cell(65);
		// whole rect gone in the top pass, aligned and unaligned
		query_rect(0, 0, 256, 256);
		query_rect(1, 1, 129, 129);
		mark_cell(GRID_CELLS - 1);
		query_rect(8064, 8064, 8192, 8192);
		mark_cell(128);
		mark_cell(129);
		mark_cell(130);
		query_rect(0, 256, 384, 512);
		mark_cell(192);
		mark_cell(194);
		// top row trimmed, then left and right columns
		query_rect(0, 256, 384, 512);
		// bottom row trimmed
		query_rect(256, 0, 384, 384);
		send_beat(OP_SPARE, pack_request(4095, 8191, 8191, 16383, 16383));
		// widest fields: columns past the stride alias into later rows
		query_rect(0, 0, 16383, 16383);
		send_beat(OP_CLEAR, pack_request(0, 0, 0, 0, 0));
		query_rect(0, 0, 256, 256);

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph > 0) begin
				drain_block();
				set_grid_shift(shift_plan[ph]);
			end
			tx_idle_pct = tx_plan[ph % 4];
			rx_stall_pct <= rx_plan[ph % 4];
			// long output hold-off while queries keep coming
			if (ph == 2) begin
				squeeze_req <= 1'b1;
				repeat (6) query_rect($urandom_range(0, 8191), $urandom_range(0, 8191),
					$urandom_range(0, 8192), $urandom_range(0, 8192));
			end
			target = (ph + 1) * ITEM_TARGET / PHASES;
			while (items_sent < target) begin
				if ($urandom_range(4) != 0)
					run_region();
				else
					send_noise();
			end
		end
		drain_block();

		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/gcur_pkg.sv
hw/rtl/gcur_ram.sv
hw/rtl/grid_cache_uncovered_rect_shrink_core.sv
tb/grid_cache_uncovered_rect_shrink_core_tb.sv
